>>> rtl/gww_pkg.sv
`timescale 1ns / 1ps

package gww_pkg;

  // Byte codes with a meaning of their own.
  localparam logic [7:0] CH_END     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Field and state widths.
  localparam int unsigned WIDTH_W  = 10;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned LINES_W  = 17;
  localparam int unsigned WORD_W   = 11;

  // Reset values and saturation limits.
  localparam logic [WIDTH_W-1:0] WRAP_WIDTH_RESET = 10'd80;
  localparam logic [WIDTH_W-1:0] COLUMN_MAX       = 10'd1023;
  localparam logic [LINES_W-1:0] LINES_MAX        = 17'h1FFFF;

  // Default text length limit in bytes.
  localparam int unsigned MAX_TEXT_BYTES_DEF = 65536;

  // One result item.
  typedef struct packed {
    logic [OFFSET_W-1:0] line_start;
    logic [LINES_W-1:0]  line_total;
    logic                is_end;
    logic                offset_overflow;
  } gww_result_t;

endpackage

>>> rtl/greedy_word_wrap.sv
`timescale 1ns / 1ps

// Greedy word wrap over a byte stream: every byte on in_char_byte is one transfer,
// and each wrapped line after the first yields one result carrying the byte offset
// where it begins; a zero byte ends the text, yields a result with is_end set and
// the total line count, and clears the text state. The block takes one byte per
// clock cycle while the output register is not stalled; a byte is registered in the
// input register on its transfer, and any result it yields is written into the output
// register when that register is free, which raises out_valid. The rate is set by
// the combinational column and word-length update between the input register and
// the output register. wrap_width (1..1023, 80 after reset, 0 acts as 1) is written
// through cfg_wr_en; the user must write it only while idle, which the block does
// not enforce, and it applies from the next byte. Offsets saturate at the smaller
// of MAX_TEXT_BYTES-1 and 65535, which sets offset_overflow for the rest of that text.
module greedy_word_wrap
  import gww_pkg::*;
#(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [WIDTH_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHAR_W-1:0]   in_char_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OFFSET_W-1:0] out_line_start,
  output logic [LINES_W-1:0]  out_line_total,
  output logic                out_is_end,
  output logic                out_offset_overflow
);

  logic              byte_valid;
  logic [CHAR_W-1:0] byte_data;
  logic              out_free;
  logic              proc;
  logic              res_valid;
  gww_result_t       res;

  // A registered byte is processed whenever the output register can take its result.
  assign proc = byte_valid && out_free;

  gww_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .take         (proc),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  gww_core #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .proc        (proc),
    .char_byte   (byte_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  gww_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid           (res_valid),
    .res                 (res),
    .out_free            (out_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_line_start      (out_line_start),
    .out_line_total      (out_line_total),
    .out_is_end          (out_is_end),
    .out_offset_overflow (out_offset_overflow)
  );

endmodule

>>> rtl/gww_in_stage.sv
`timescale 1ns / 1ps

module gww_in_stage
  import gww_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char_byte,
  input  logic              take,
  output logic              byte_valid,
  output logic [CHAR_W-1:0] byte_data
);

  logic              valid_r;
  logic              valid_nxt;
  logic [CHAR_W-1:0] byte_r;

  // The register is free when empty or when its byte is consumed this cycle.
  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_valid || (valid_r && !take);
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  // Valid flag follows the transfers on both sides.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // Payload is loaded on every input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_char_byte;
    end
  end

endmodule

>>> rtl/gww_core.sv
`timescale 1ns / 1ps

module gww_core
  import gww_pkg::*;
#(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  input  logic               proc,
  input  logic [CHAR_W-1:0]  char_byte,
  output logic               res_valid,
  output gww_result_t        res
);

  // Offsets saturate at the smaller of the text limit minus one and the field maximum.
  localparam logic [OFFSET_W-1:0] OFFSET_CAP =
    (MAX_TEXT_BYTES - 1 > 65535) ? 16'hFFFF : OFFSET_W'(MAX_TEXT_BYTES - 1);

  logic [WIDTH_W-1:0]  wrap_width_r;
  logic [WIDTH_W-1:0]  column_r,        column_nxt;
  logic [WORD_W-1:0]   word_length_r,   word_length_nxt;
  logic [OFFSET_W-1:0] word_begin_r,    word_begin_nxt;
  logic [OFFSET_W-1:0] byte_position_r, byte_position_nxt;
  logic [LINES_W-1:0]  lines_so_far_r,  lines_so_far_nxt;
  logic                overflowed_r,    overflowed_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [WORD_W:0]     w_ext;
  logic                at_cap;
  logic [OFFSET_W-1:0] pos_next;
  logic                ovf_new;
  logic [LINES_W-1:0]  lines_inc;
  logic [WORD_W:0]     space_sum;
  logic [WIDTH_W-1:0]  column_sat;
  logic [WORD_W-1:0]   wl_inc;
  logic [WORD_W:0]     word_sum;

  // Width register; it must be written only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_width_r <= WRAP_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      wrap_width_r <= cfg_wr_data;
    end
  end

  // Shared terms of the byte update.
  always_comb begin
    w_eff      = (wrap_width_r == '0) ? WIDTH_W'(1) : wrap_width_r;
    w_ext      = {2'b00, w_eff};
    at_cap     = (byte_position_r >= OFFSET_CAP);
    pos_next   = at_cap ? OFFSET_CAP : byte_position_r + OFFSET_W'(1);
    ovf_new    = overflowed_r || at_cap;
    lines_inc  = (lines_so_far_r == LINES_MAX) ? lines_so_far_r
                                               : lines_so_far_r + LINES_W'(1);
    space_sum  = {2'b00, column_r} + {1'b0, word_length_r} + (WORD_W+1)'(1);
    column_sat = (space_sum > {2'b00, COLUMN_MAX}) ? COLUMN_MAX : space_sum[WIDTH_W-1:0];
    wl_inc     = word_length_r + WORD_W'(1);
    word_sum   = {2'b00, column_r} + {1'b0, wl_inc};
  end

  // Next state and result for the byte being processed.
  always_comb begin
    column_nxt        = column_r;
    word_length_nxt   = word_length_r;
    word_begin_nxt    = word_begin_r;
    byte_position_nxt = byte_position_r;
    lines_so_far_nxt  = lines_so_far_r;
    overflowed_nxt    = overflowed_r;
    res_valid         = 1'b0;
    res.line_start      = '0;
    res.line_total      = '0;
    res.is_end          = 1'b0;
    res.offset_overflow = ovf_new;
    if (proc) begin
      if (char_byte != CH_END) begin
        byte_position_nxt = pos_next;
        overflowed_nxt    = ovf_new;
      end
      unique case (char_byte)
        CH_END: begin
          // End of text: report the line count and start over.
          res_valid           = 1'b1;
          res.line_total      = lines_so_far_r;
          res.is_end          = 1'b1;
          res.offset_overflow = overflowed_r;
          column_nxt          = '0;
          word_length_nxt     = '0;
          word_begin_nxt      = '0;
          byte_position_nxt   = '0;
          lines_so_far_nxt    = LINES_W'(1);
          overflowed_nxt      = 1'b0;
        end
        CH_NEWLINE: begin
          // Forced break after the newline.
          res_valid        = 1'b1;
          res.line_start   = pos_next;
          lines_so_far_nxt = lines_inc;
          column_nxt       = '0;
          word_begin_nxt   = pos_next;
          word_length_nxt  = '0;
        end
        CH_SPACE: begin
          // A space that overflows a nonempty line breaks after itself.
          if (space_sum > w_ext && column_r != '0) begin
            res_valid        = 1'b1;
            res.line_start   = pos_next;
            lines_so_far_nxt = lines_inc;
            column_nxt       = '0;
          end else begin
            column_nxt = column_sat;
          end
          word_begin_nxt  = pos_next;
          word_length_nxt = '0;
        end
        default: begin
          // Word byte: move the word down, or split it when it is too long.
          word_length_nxt = wl_inc;
          if (word_sum > w_ext) begin
            if (column_r != '0 && {1'b0, wl_inc} <= w_ext) begin
              res_valid        = 1'b1;
              res.line_start   = word_begin_r;
              lines_so_far_nxt = lines_inc;
              column_nxt       = '0;
            end else if ({1'b0, wl_inc} > w_ext) begin
              res_valid        = 1'b1;
              res.line_start   = byte_position_r;
              lines_so_far_nxt = lines_inc;
              column_nxt       = '0;
              word_begin_nxt   = byte_position_r;
              word_length_nxt  = WORD_W'(1);
            end
          end
        end
      endcase
    end
  end

  // Text state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r        <= '0;
      word_length_r   <= '0;
      word_begin_r    <= '0;
      byte_position_r <= '0;
      lines_so_far_r  <= LINES_W'(1);
      overflowed_r    <= 1'b0;
    end else begin
      column_r        <= column_nxt;
      word_length_r   <= word_length_nxt;
      word_begin_r    <= word_begin_nxt;
      byte_position_r <= byte_position_nxt;
      lines_so_far_r  <= lines_so_far_nxt;
      overflowed_r    <= overflowed_nxt;
    end
  end

  // A word in progress never grows past the widest line.
  a_word_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !word_length_r[WORD_W-1])
    else $error("word length exceeds the widest line");

  // The position never passes the offset cap.
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= OFFSET_CAP)
    else $error("byte position passed the offset cap");

  // An end-of-text byte leaves a cleared text state behind.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && char_byte == CH_END) |=>
      (byte_position_r == '0 && lines_so_far_r == LINES_W'(1) && column_r == '0
       && !overflowed_r))
    else $error("text state not cleared after end of text");

  // Overflow is only flagged once the position has reached the cap.
  a_ovf_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    overflowed_r |-> byte_position_r == OFFSET_CAP)
    else $error("overflow flagged below the offset cap");

endmodule

>>> rtl/gww_out_reg.sv
`timescale 1ns / 1ps

module gww_out_reg
  import gww_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  gww_result_t         res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OFFSET_W-1:0] out_line_start,
  output logic [LINES_W-1:0]  out_line_total,
  output logic                out_is_end,
  output logic                out_offset_overflow
);

  logic        valid_r;
  gww_result_t data_r;

  // A new result may be written when the register is empty or being drained.
  assign out_free = !valid_r || out_ready;

  // Valid flag: set by a new result, cleared by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_line_start      = data_r.line_start;
  assign out_line_total      = data_r.line_total;
  assign out_is_end          = data_r.is_end;
  assign out_offset_overflow = data_r.offset_overflow;

  // A result is only written into a register that is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result written over an unsent result");

  // End-of-text results carry a line count of at least one.
  a_end_total: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.is_end) |-> data_r.line_total != '0)
    else $error("end-of-text result with zero line count");

  // Line-start results carry no line count.
  a_start_total: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !data_r.is_end) |-> data_r.line_total == '0)
    else $error("line-start result with a line count");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import gww_pkg::*;

  // Largest byte offset the block can report before it saturates.
  localparam int unsigned OFFSET_CAP =
    (MAX_TEXT_BYTES_DEF - 1 > 65535) ? 65535 : MAX_TEXT_BYTES_DEF - 1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 95;
  localparam int unsigned LONG_NEWLINES = 20;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned BUSY_PCT      = 46;
  localparam int unsigned BOTH_PCT      = 29;
  localparam int unsigned TIMEOUT_NS    = 2000000;

  // Tracks the wrap state of the text in flight and holds the results it implies.
  class wrap_tracker;
    logic [WIDTH_W-1:0]  wrap_width;
    logic [WIDTH_W-1:0]  column;
    logic [WORD_W-1:0]   word_bytes;
    logic [OFFSET_W-1:0] word_head;
    logic [OFFSET_W-1:0] pos;
    logic [LINES_W-1:0]  lines;
    logic                ovf;
    gww_result_t         pending_breaks[$];
    int unsigned         errors;
    int unsigned         starts_seen;
    int unsigned         ends_seen;

    function new();
      wrap_width  = WRAP_WIDTH_RESET;
      errors      = 0;
      starts_seen = 0;
      ends_seen   = 0;
      clear_text();
    endfunction

    function void clear_text();
      column     = '0;
      word_bytes = '0;
      word_head  = '0;
      pos        = '0;
      lines      = LINES_W'(1);
      ovf        = 1'b0;
    endfunction

    function void count_line();
      if (lines != LINES_MAX) lines = lines + 1'b1;
    endfunction

    function void expect_start(input int unsigned start);
      gww_result_t r;
      r.line_start      = start[OFFSET_W-1:0];
      r.line_total      = '0;
      r.is_end          = 1'b0;
      r.offset_overflow = ovf;
      pending_breaks.push_back(r);
    endfunction

    // Applies one transferred byte to the wrap state.
    function void take_byte(input logic [CHAR_W-1:0] b);
      int unsigned w;
      int unsigned nxt;
      int unsigned sum;
      gww_result_t r;
      w = (wrap_width == 0) ? 1 : wrap_width;
      if (b == CH_END) begin
        r.line_start      = '0;
        r.line_total      = lines;
        r.is_end          = 1'b1;
        r.offset_overflow = ovf;
        pending_breaks.push_back(r);
        clear_text();
        return;
      end
      // The offset after this byte holds at the cap once the text is too long.
      if (pos >= OFFSET_CAP) begin
        nxt = OFFSET_CAP;
        ovf = 1'b1;
      end else begin
        nxt = pos + 1;
      end
      if (b == CH_NEWLINE) begin
        count_line();
        column     = '0;
        word_head  = nxt[OFFSET_W-1:0];
        word_bytes = '0;
        expect_start(nxt);
      end else if (b == CH_SPACE) begin
        sum = column + word_bytes + 1;
        if (sum > w && column != 0) begin
          count_line();
          column = '0;
          expect_start(nxt);
        end else begin
          column = (sum > COLUMN_MAX) ? COLUMN_MAX : sum[WIDTH_W-1:0];
        end
        word_head  = nxt[OFFSET_W-1:0];
        word_bytes = '0;
      end else begin
        word_bytes = word_bytes + 1'b1;
        sum = column + word_bytes;
        if (sum > w) begin
          if (column != 0 && word_bytes <= w) begin
            // The whole word moves to a new line.
            count_line();
            column = '0;
            expect_start(word_head);
          end else if (word_bytes > w) begin
            // The word alone is too wide, so it is split before this byte.
            count_line();
            column     = '0;
            word_head  = pos;
            word_bytes = WORD_W'(1);
            expect_start(pos);
          end
        end
      end
      pos = nxt[OFFSET_W-1:0];
    endfunction

    // Compares one transferred result with the oldest one expected.
    function void match_result(input gww_result_t got);
      gww_result_t want;
      if (pending_breaks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result start %0d total %0d end %0b overflow %0b",
                 $time, got.line_start, got.line_total, got.is_end, got.offset_overflow);
        return;
      end
      want = pending_breaks.pop_front();
      if (want.is_end) ends_seen++;
      else starts_seen++;
      if (got.line_start !== want.line_start) begin
        errors++;
        $display("%0t: line_start expected %0d actual %0d",
                 $time, want.line_start, got.line_start);
      end
      if (got.line_total !== want.line_total) begin
        errors++;
        $display("%0t: line_total expected %0d actual %0d",
                 $time, want.line_total, got.line_total);
      end
      if (got.is_end !== want.is_end) begin
        errors++;
        $display("%0t: is_end expected %0b actual %0b", $time, want.is_end, got.is_end);
      end
      if (got.offset_overflow !== want.offset_overflow) begin
        errors++;
        $display("%0t: offset_overflow expected %0b actual %0b",
                 $time, want.offset_overflow, got.offset_overflow);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [WIDTH_W-1:0]  cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_char_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OFFSET_W-1:0] out_line_start;
  logic [LINES_W-1:0]  out_line_total;
  logic                out_is_end;
  logic                out_offset_overflow;

  wrap_tracker  tracker = new();
  gww_result_t  seen_result;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  items_sent = 0;
  int unsigned  widths_written = 0;

  greedy_word_wrap dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_char_byte        (in_char_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_line_start      (out_line_start),
    .out_line_total      (out_line_total),
    .out_is_end          (out_is_end),
    .out_offset_overflow (out_offset_overflow)
  );

  always #1 clk = ~clk;

  // The receiver stalls at random while a stall rate is set.
  always @(negedge clk) begin
    out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.line_start      = out_line_start;
      seen_result.line_total      = out_line_total;
      seen_result.is_end          = out_is_end;
      seen_result.offset_overflow = out_offset_overflow;
      tracker.match_result(seen_result);
    end
  end

  // Offers one byte, with random gaps first, and returns at the falling edge after
  // its transfer.
  task automatic send_byte(input logic [CHAR_W-1:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_NEWLINE || c == CH_SPACE);
    return c;
  endfunction

  // Writes the width once the block has gone quiet; a text may still be open.
  task automatic write_width(input logic [WIDTH_W-1:0] w);
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_breaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.wrap_width = w;
    widths_written++;
  endtask

  // Sends a short text of words and separators, or now and then a burst of raw bytes.
  task automatic send_text(input int unsigned w);
    int unsigned n;
    int unsigned k;
    int unsigned wl;
    int unsigned cap;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) send_byte(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    cap = (w < 12) ? w + 3 : 12;
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      // Now and then a word wider than a narrow line, to force a split.
      if (w < 40 && $urandom_range(99) < 10) wl = $urandom_range(w + 1, w + 8);
      else wl = $urandom_range(1, cap);
      repeat (wl) send_byte(word_char());
      case ($urandom_range(9))
        0: send_byte(CH_NEWLINE);
        1: begin
          send_byte(CH_SPACE);
          send_byte(CH_SPACE);
        end
        default: send_byte(CH_SPACE);
      endcase
    end
    // Some texts stay open so that the next width applies mid-text.
    if ($urandom_range(99) < 85) send_byte(CH_END);
  endtask

  initial begin
    int unsigned ph;
    int unsigned start;
    int unsigned w;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An empty text at the reset width reports a single line.
    send_byte(CH_END);

    // A width of zero behaves as a width of one.
    write_width('0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_SPACE);
    send_byte(8'h41);
    send_byte(CH_END);

    // A narrow line: an overflowing space, a split word and a newline.
    write_width(10'd5);
    send_string("ab cd efghijklm\nxy");
    send_byte(CH_END);

    // Widest line: a full-width word then a space drives the column to saturation,
    // and a run of newlines follows.
    write_width(10'd1023);
    repeat (1023) send_byte(word_char());
    send_byte(CH_SPACE);
    send_string("ab ");
    repeat (LONG_NEWLINES) send_byte(CH_NEWLINE);
    send_string("xy z");
    send_byte(CH_END);

    // Random texts under several widths and idling patterns.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = BUSY_PCT;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = BUSY_PCT;
        end
        default: begin
          tx_idle_pct  = BOTH_PCT;
          rx_stall_pct = BOTH_PCT;
        end
      endcase
      case (ph)
        0: w = 1;
        1: w = 1023;
        2: w = 3;
        3: w = 9;
        4: w = $urandom_range(2, 40);
        5: w = $urandom_range(41, 1022);
        6: w = 16;
        default: w = 2;
      endcase
      write_width(w[WIDTH_W-1:0]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_text(w);
    end
    send_byte(CH_END);

    // Let every result drain, then let the block settle.
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_breaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d bytes under %0d width settings and four idling patterns.",
             items_sent, widths_written);
    $display("Checked %0d line starts and %0d end-of-text counts.",
             tracker.starts_seen, tracker.ends_seen);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected.", tracker.pending_breaks.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
rtl/gww_pkg.sv
rtl/gww_in_stage.sv
rtl/gww_core.sv
rtl/gww_out_reg.sv
rtl/greedy_word_wrap.sv
sim/tb.sv
